/* rtl/spgpm_pkg.sv */
package spgpm_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int PAN_TABLE_DEPTH = 256;

  localparam int CTL_W  = 16;
  localparam int PT_AW  = $clog2(PAN_TABLE_DEPTH + 1);
  localparam int MUL_W  = ((SAMPLE_BITS > CTL_W) ? SAMPLE_BITS : CTL_W) + 2;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [63:0]      HALF_PI_Q30 = 64'd1686629713;
  localparam logic [CTL_W-1:0] VOL_MAX     = CTL_W'(32768);
  localparam logic [CTL_W-1:0] PAN_LIM     = CTL_W'(16384);
  localparam logic [CTL_W-1:0] DECAY_Q15   = CTL_W'(31130);
  localparam logic [CTL_W-1:0] UNITY_Q15   = CTL_W'(32768);

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_NONE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_GL   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_GR   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_OL   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_OR   = 3'd4;
  localparam logic [STEP_W-1:0] STEP_PK   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_ML   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_MR   = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic        [CTL_W-1:0]       volume;
    logic signed [CTL_W-1:0]       pan;
    logic                          block_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic        [SAMPLE_BITS-1:0] level_left;
    logic        [SAMPLE_BITS-1:0] level_right;
    logic                          levels_updated;
  } out_t;

  typedef struct packed {
    logic              capture;
    logic [STEP_W-1:0] step;
    logic              load_out;
  } cmd_t;

  typedef logic [PAN_TABLE_DEPTH:0][CTL_W-1:0] sine_rom_t;

  // shift-and-subtract quotient, evaluated only while the table is built
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] div;
    for (int k = 0; k <= PAN_TABLE_DEPTH; k++) begin
      x    = div_u64(HALF_PI_Q30 * 64'(k), 64'(PAN_TABLE_DEPTH));
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
        div  = 64'((2 * n) * (2 * n + 1));
        term = div_u64((term * x2) >> 30, div);
        if (n[0] == 1'b1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum + 64'd16384) >> 15;
      rom[k] = (sum > 64'(UNITY_Q15)) ? UNITY_Q15 : sum[CTL_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* rtl/spgpm_ctrl.sv */
module spgpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spgpm_pkg::cmd_t   cmd
);
  import spgpm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_GL   = 4'd1;
  localparam logic [3:0] S_GR   = 4'd2;
  localparam logic [3:0] S_OL   = 4'd3;
  localparam logic [3:0] S_OR   = 4'd4;
  localparam logic [3:0] S_PK   = 4'd5;
  localparam logic [3:0] S_ML   = 4'd6;
  localparam logic [3:0] S_MR   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.step     = STEP_NONE;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_GL;
        end
      end
      S_GL: begin
        cmd.step  = STEP_GL;
        state_nxt = S_GR;
      end
      S_GR: begin
        cmd.step  = STEP_GR;
        state_nxt = S_OL;
      end
      S_OL: begin
        cmd.step  = STEP_OL;
        state_nxt = S_OR;
      end
      S_OR: begin
        cmd.step  = STEP_OR;
        state_nxt = S_PK;
      end
      S_PK: begin
        cmd.step  = STEP_PK;
        state_nxt = S_ML;
      end
      S_ML: begin
        cmd.step  = STEP_ML;
        state_nxt = S_MR;
      end
      S_MR: begin
        cmd.step  = STEP_MR;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/spgpm_dp.sv */
module spgpm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  spgpm_pkg::in_t    in_data,
  input  spgpm_pkg::cmd_t   cmd,
  output spgpm_pkg::out_t   out_data
);
  import spgpm_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int KP_W = CTL_W + PT_AW + 1;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

  logic                     mute_r;
  logic signed [SB-1:0]     sl_r, sr_r;
  logic [CTL_W-1:0]         vol_r;
  logic [PT_AW-1:0]         k_r;
  logic                     last_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [CTL_W-1:0]         gl_r, gr_r;
  logic signed [SB-1:0]     ol_r, or_r;
  logic [SB-1:0]            peak_l_r, peak_r_r, meter_l_r, meter_r_r;
  out_t                     out_r;

  logic [CTL_W-1:0]         vol_c;
  logic signed [CTL_W-1:0]  pan_c;
  logic [CTL_W-1:0]         t_c;
  logic [KP_W-1:0]          kp_c;
  logic [KP_W-1:0]          ks_c;
  logic [PT_AW-1:0]         k_c;

  logic [PT_AW-1:0]         rom_addr;
  logic [CTL_W-1:0]         rom_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  logic signed [PROD_W-1:0] gain_w, samp_w;
  logic [CTL_W-1:0]         gain_q;
  logic signed [SB-1:0]     sat_q;
  logic [SB-1:0]            mag_q;
  logic [SB-1:0]            decay_q;

  // clamp and index the incoming transaction
  always_comb begin
    vol_c = (in_data.volume > VOL_MAX) ? VOL_MAX : in_data.volume;
    if (in_data.pan > $signed(PAN_LIM)) begin
      pan_c = $signed(PAN_LIM);
    end else if (in_data.pan < -$signed(PAN_LIM)) begin
      pan_c = -$signed(PAN_LIM);
    end else begin
      pan_c = in_data.pan;
    end
    t_c  = CTL_W'(pan_c + $signed(PAN_LIM));
    kp_c = KP_W'(t_c) * KP_W'(PAN_TABLE_DEPTH) + KP_W'(16384);
    ks_c = kp_c >> 15;
    k_c  = (ks_c > KP_W'(PAN_TABLE_DEPTH)) ? PT_AW'(PAN_TABLE_DEPTH) : ks_c[PT_AW-1:0];
  end

  assign rom_addr = (cmd.step == STEP_GL) ? (PT_AW'(PAN_TABLE_DEPTH) - k_r) : k_r;
  assign rom_q    = SINE_ROM[rom_addr];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_GL, STEP_GR: begin
        mul_a = $signed(MUL_W'(vol_r));
        mul_b = $signed(MUL_W'(rom_q));
      end
      STEP_OL: begin
        mul_a = MUL_W'(sl_r);
        mul_b = $signed(MUL_W'(gl_r));
      end
      STEP_OR: begin
        mul_a = MUL_W'(sr_r);
        mul_b = $signed(MUL_W'(gr_r));
      end
      STEP_PK: begin
        mul_a = $signed(MUL_W'(meter_l_r));
        mul_b = $signed(MUL_W'(DECAY_Q15));
      end
      STEP_ML: begin
        mul_a = $signed(MUL_W'(meter_r_r));
        mul_b = $signed(MUL_W'(DECAY_Q15));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    gain_w  = (prod_r + PROD_W'(16384)) >>> 15;
    gain_q  = gain_w[CTL_W-1:0];
    samp_w  = (prod_r + PROD_W'(8192)) >>> 14;
    if (samp_w > SAT_HI) begin
      sat_q = SAT_HI[SB-1:0];
    end else if (samp_w < SAT_LO) begin
      sat_q = SAT_LO[SB-1:0];
    end else begin
      sat_q = samp_w[SB-1:0];
    end
    mag_q   = sat_q[SB-1] ? SB'(-sat_q) : SB'(sat_q);
    decay_q = SB'(prod_r >>> 15);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_r    <= 1'b0;
      peak_l_r  <= '0;
      peak_r_r  <= '0;
      meter_l_r <= '0;
      meter_r_r <= '0;
    end else begin
      if (cfg_we) begin
        mute_r <= cfg_wdata;
      end
      case (cmd.step)
        STEP_OR: begin
          if (mag_q > peak_l_r) begin
            peak_l_r <= mag_q;
          end
        end
        STEP_PK: begin
          if (mag_q > peak_r_r) begin
            peak_r_r <= mag_q;
          end
        end
        STEP_ML: begin
          if (last_r) begin
            meter_l_r <= (peak_l_r > meter_l_r) ? peak_l_r : decay_q;
            peak_l_r  <= '0;
          end
        end
        STEP_MR: begin
          if (last_r) begin
            meter_r_r <= (peak_r_r > meter_r_r) ? peak_r_r : decay_q;
            peak_r_r  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sl_r   <= in_data.sample_left;
      sr_r   <= in_data.sample_right;
      vol_r  <= vol_c;
      k_r    <= k_c;
      last_r <= in_data.block_last;
    end
    if (cmd.step != STEP_NONE) begin
      prod_r <= prod_nxt;
    end
    case (cmd.step)
      STEP_GR: gl_r <= gain_q;
      STEP_OL: gr_r <= gain_q;
      STEP_OR: ol_r <= sat_q;
      STEP_PK: or_r <= sat_q;
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_r.out_left       <= mute_r ? '0 : ol_r;
      out_r.out_right      <= mute_r ? '0 : or_r;
      out_r.level_left     <= meter_l_r;
      out_r.level_right    <= meter_r_r;
      out_r.levels_updated <= last_r;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/stereo_pan_gain_peak_meter_top.sv */
// Stereo equal-power pan with volume and block peak meters.
//
// Input channel (in_valid / in_stall / in_data): one stereo sample with its
// volume, pan and block_last flag per transaction. Result channel (out_valid /
// out_stall / out_data): one result per input transaction, carrying the panned
// and saturated samples plus both meter levels after any block-end update.
// Configuration: cfg_we with cfg_wdata writes the mute bit, which zeroes the
// audio outputs while the meters keep tracking.
//
// Each item passes through capture, seven datapath steps (six products on the
// single shared multiplier for two gains, two samples and two meter decays,
// then the last meter update) and result load, all in sequence; in_stall
// holds off the next input transaction until the result load.
// The result sits in an output register, so the next input transaction is
// accepted while it waits; a result still stalled when the following one is
// ready holds the controller before loading that one.
//
// Synchronous reset clears mute, peaks, meters and out_valid.
module stereo_pan_gain_peak_meter_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  spgpm_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spgpm_pkg::out_t   out_data
);
  import spgpm_pkg::*;

  cmd_t cmd;

  spgpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spgpm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

/* rtl/spgpm_chk.sv */
module spgpm_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input spgpm_pkg::out_t   out_data
);
  import spgpm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again while busy");

  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("input not free when result appears");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.level_left <= UNITY_Q15) &&
                  (out_data.level_right <= UNITY_Q15))
    else $error("meter level out of range");

endmodule

bind stereo_pan_gain_peak_meter_top spgpm_chk u_chk (.*);
